@@ rtl/ssm_pkg.sv @@
// ssm_pkg: shared item types and register indexes for the speech segment merger
// used by speech_segment_merger; no dependencies
`timescale 1ns / 1ps

package ssm_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_MODE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP_FRAMES    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH_FRAMES = 2'd2;

  localparam int unsigned CFG_DATA_W = 8;

  // reset values of the registers (20 frames = 0.2 s at 10 ms per frame)
  localparam logic [7:0] MIN_GAP_RESET    = 8'd20;
  localparam logic [7:0] MIN_LENGTH_RESET = 8'd20;

  // one frame flag
  typedef struct packed {
    logic speech;
    logic final_frame;
  } in_item_t;

  // one emitted segment
  typedef struct packed {
    logic [31:0] seg_start;
    logic [31:0] seg_end;
    logic        last_in_run;
  } out_item_t;

endpackage

@@ rtl/speech_segment_merger.sv @@
// speech_segment_merger: merges per-frame speech flags into frame-indexed segments
// depends on ssm_pkg (item types, register indexes)
`timescale 1ns / 1ps

// Usage
//   in_item carries one frame flag (speech, final_frame) per item on a valid/ready
//   channel; out_item carries segments (seg_start, seg_end, last_in_run) on a
//   valid/ready channel. cfg_we writes cfg_wdata to register cfg_index;
//   write only while no item is in flight.
//   An accepted item is registered, then processed when the queue has room, which
//   updates the stream state and pushes zero, one or two segments into a four-entry
//   output queue. One item is taken per cycle as long as the queue has room for two
//   segments; the queue drains one segment per cycle while out_ready is high, so
//   items that each produce segments are limited by that single output port.
//   A stalled receiver fills the queue, after which in_ready drops; nothing is lost.
//   The final_frame item flushes the held segment and restarts the frame count at 0.
//   Reset (rst_n low, synchronous) clears the stream state and queue and loads the
//   register defaults: invert_mode 0, min_gap_frames 20, min_length_frames 20.
module speech_segment_merger
  import ssm_pkg::*;
#(
  parameter int unsigned FRAME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned FB = FRAME_BITS;

  typedef logic [FB-1:0] frame_t;

  typedef struct packed {
    logic   valid;
    frame_t start;
    frame_t stop;
  } seg_t;

  typedef struct packed {
    seg_t held;
    seg_t emit;
  } offer_res_t;

  // configuration registers
  logic       invert_mode_r;
  logic [7:0] min_gap_r;
  logic [7:0] min_length_r;

  // stream state
  frame_t frame_count_r, frame_count_nxt;
  logic   run_open_r, run_open_nxt;
  frame_t run_start_r, run_start_nxt;
  seg_t   held_r, held_nxt;

  // input register
  logic     s1_valid_r;
  in_item_t s1_item_r;
  logic     s1_fire;

  // output queue
  out_item_t q_mem [4];
  logic [1:0] q_wr_r, q_rd_r;
  logic [2:0] q_cnt_r;
  logic [1:0] push_n;
  out_item_t push0, push1;
  logic       pop;

  // release of a held segment: emitted when non-empty and long enough
  function automatic seg_t release_seg(seg_t h, logic [7:0] min_len);
    seg_t   em;
    frame_t len;
    len = h.stop - h.start;
    em  = h;
    em.valid = h.valid && (h.stop > h.start) && (len >= {{(FB-8){1'b0}}, min_len});
    return em;
  endfunction

  // offer a raw segment: merge into the held one or release and replace it
  function automatic offer_res_t offer_seg(seg_t h, frame_t s, frame_t e,
                                           logic [7:0] min_gap, logic [7:0] min_len);
    offer_res_t r;
    frame_t     gap;
    gap = (s >= h.stop) ? (s - h.stop) : '0;
    r.held = h;
    r.emit = '0;
    if (h.valid && (gap < {{(FB-8){1'b0}}, min_gap})) begin
      r.held.stop = e;
    end else begin
      r.emit = release_seg(h, min_len);
      r.held.valid = 1'b1;
      r.held.start = s;
      r.held.stop  = e;
    end
    return r;
  endfunction

  // frame index to 32-bit output field
  function automatic logic [31:0] to_out(frame_t v);
    logic [FB+31:0] ext;
    ext = {32'b0, v};
    return ext[31:0];
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_mode_r <= 1'b0;
      min_gap_r     <= MIN_GAP_RESET;
      min_length_r  <= MIN_LENGTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INVERT_MODE:       invert_mode_r <= cfg_wdata[0];
        CFG_MIN_GAP_FRAMES:    min_gap_r     <= cfg_wdata;
        CFG_MIN_LENGTH_FRAMES: min_length_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register, advances when the queue has room for two segments
  assign s1_fire  = s1_valid_r && (q_cnt_r <= 3'd2);
  assign in_ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_item;
    end
  end

  // segment logic for the registered item
  always_comb begin
    frame_t     cur, nxt;
    logic       sp, fin, inv, off_a;
    frame_t     b_start;
    offer_res_t ra, rb;
    seg_t       h1, h2, em_a, em_b, em_c, rel;
    sp  = s1_item_r.speech;
    fin = s1_item_r.final_frame;
    inv = invert_mode_r;
    cur = frame_count_r;
    nxt = (cur != '1) ? cur + frame_t'(1) : cur;

    // run transition closes a raw segment (speech run or gap by mode)
    off_a = (sp && !run_open_r && inv) || (!sp && run_open_r && !inv);
    ra = offer_seg(held_r, run_start_r, cur, min_gap_r, min_length_r);
    h1   = off_a ? ra.held : held_r;
    em_a = off_a ? ra.emit : '0;

    run_open_nxt  = sp;
    run_start_nxt = (sp != run_open_r) ? cur : run_start_r;

    // final frame closes the open segment, then flushes the held one
    b_start = (sp && inv) ? nxt : run_start_nxt;
    rb = offer_seg(h1, b_start, nxt, min_gap_r, min_length_r);
    h2   = (fin && (sp || inv)) ? rb.held : h1;
    em_b = (fin && (sp || inv)) ? rb.emit : '0;
    rel  = release_seg(h2, min_length_r);
    em_c = fin ? rel : '0;

    held_nxt      = h2;
    frame_count_nxt = nxt;
    if (fin) begin
      held_nxt        = '0;
      frame_count_nxt = '0;
      run_open_nxt    = 1'b0;
      run_start_nxt   = '0;
    end

    // pick the first two emitted segments in order
    push0 = '0;
    push1 = '0;
    push_n = 2'd0;
    if (em_a.valid) begin
      push0 = '{seg_start: to_out(em_a.start), seg_end: to_out(em_a.stop), last_in_run: 1'b0};
      push_n = 2'd1;
    end
    if (em_b.valid) begin
      if (push_n == 2'd0) begin
        push0 = '{seg_start: to_out(em_b.start), seg_end: to_out(em_b.stop),
                  last_in_run: 1'b0};
        push_n = 2'd1;
      end else begin
        push1 = '{seg_start: to_out(em_b.start), seg_end: to_out(em_b.stop),
                  last_in_run: 1'b0};
        push_n = 2'd2;
      end
    end
    if (em_c.valid) begin
      if (push_n == 2'd0) begin
        push0 = '{seg_start: to_out(em_c.start), seg_end: to_out(em_c.stop),
                  last_in_run: 1'b0};
        push_n = 2'd1;
      end else if (push_n == 2'd1) begin
        push1 = '{seg_start: to_out(em_c.start), seg_end: to_out(em_c.stop),
                  last_in_run: 1'b0};
        push_n = 2'd2;
      end
    end
    if (push_n == 2'd1) begin
      push0.last_in_run = 1'b1;
    end
    if (push_n == 2'd2) begin
      push1.last_in_run = 1'b1;
    end
    if (!s1_fire) begin
      push_n = 2'd0;
    end
  end

  // stream state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= '0;
      run_open_r    <= 1'b0;
      run_start_r   <= '0;
      held_r        <= '0;
    end else if (s1_fire) begin
      frame_count_r <= frame_count_nxt;
      run_open_r    <= run_open_nxt;
      run_start_r   <= run_start_nxt;
      held_r        <= held_nxt;
    end
  end

  // output queue
  assign out_valid = (q_cnt_r != 3'd0);
  assign out_item  = q_mem[q_rd_r];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_mem[q_wr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      q_mem[q_wr_r + 2'd1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= 2'd0;
      q_rd_r  <= 2'd0;
      q_cnt_r <= 3'd0;
    end else begin
      q_wr_r  <= q_wr_r + push_n;
      q_rd_r  <= q_rd_r + {1'b0, pop};
      q_cnt_r <= q_cnt_r + {1'b0, push_n} - {2'b0, pop};
    end
  end

endmodule

@@ dv/ssm_checker.sv @@
// ssm_checker: watches the frame, segment and register ports of speech_segment_merger,
// predicts the merged segments and compares them; depends on ssm_pkg
`timescale 1ns / 1ps

module ssm_checker
  import ssm_pkg::*;
#(
  parameter int unsigned FRAME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_item,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           fail_count,
  output int unsigned           pending_count,
  output int unsigned           seg_count
);

  typedef logic [FRAME_BITS-1:0] frame_t;
  localparam frame_t FRAME_LAST = '1;

  // register mirror
  logic       invert_q;
  logic [7:0] min_gap_q;
  logic [7:0] min_len_q;

  // stream state of the predictor
  frame_t frame_idx;
  logic   run_active;
  frame_t run_begin;
  logic   held_active;
  frame_t held_begin;
  frame_t held_stop;

  // segments still owed by the block, oldest first
  out_item_t expected_segs[$];
  out_item_t new_segs[2];
  int        new_cnt;

  int unsigned n_fail;
  int unsigned n_segs;

  task automatic report_mismatch(input string what);
    $display("[%0t] segment mismatch: %s", $time, what);
    n_fail++;
  endtask

  task automatic clear_stream();
    frame_idx   = '0;
    run_active  = 1'b0;
    run_begin   = '0;
    held_active = 1'b0;
    held_begin  = '0;
    held_stop   = '0;
  endtask

  // emit the held segment if it is long enough; empty ones never go out
  task automatic release_held_seg();
    frame_t seg_len;
    if (held_active) begin
      held_active = 1'b0;
      if (held_stop > held_begin) begin
        seg_len = held_stop - held_begin;
        if (seg_len >= min_len_q && new_cnt < 2) begin
          new_segs[new_cnt] = '{seg_start: 32'(held_begin), seg_end: 32'(held_stop),
                                last_in_run: 1'b0};
          new_cnt++;
        end
      end
    end
  endtask

  // merge a raw segment into the held one or replace it
  task automatic offer_seg(input frame_t s, input frame_t e);
    frame_t gap_len;
    gap_len = (s >= held_stop) ? s - held_stop : '0;
    if (held_active && gap_len < min_gap_q) begin
      held_stop = e;
    end else begin
      release_held_seg();
      held_active = 1'b1;
      held_begin  = s;
      held_stop   = e;
    end
  endtask

  // advance the stream by one frame and queue the segments it releases
  task automatic merge_frame(input logic sp, input logic fin);
    frame_t cur;
    frame_t nxt;
    cur = frame_idx;
    nxt = (cur != FRAME_LAST) ? cur + frame_t'(1) : cur;
    new_cnt = 0;
    if (sp) begin
      if (!run_active) begin
        if (invert_q) offer_seg(run_begin, cur);
        run_active = 1'b1;
        run_begin  = cur;
      end
    end else if (run_active) begin
      if (!invert_q) offer_seg(run_begin, cur);
      run_active = 1'b0;
      run_begin  = cur;
    end
    if (fin) begin
      if (run_active) begin
        if (!invert_q) offer_seg(run_begin, nxt);
        else offer_seg(nxt, nxt);
      end else if (invert_q) begin
        offer_seg(run_begin, nxt);
      end
      release_held_seg();
      clear_stream();
    end else begin
      frame_idx = nxt;
    end
    if (new_cnt > 0) new_segs[new_cnt-1].last_in_run = 1'b1;
    for (int k = 0; k < new_cnt; k++) expected_segs.insert(expected_segs.size(), new_segs[k]);
  endtask

  task automatic check_segment(input out_item_t got);
    out_item_t want;
    n_segs++;
    if (expected_segs.size() == 0) begin
      report_mismatch($sformatf("unexpected segment [%0d,%0d)", got.seg_start, got.seg_end));
    end else begin
      want = expected_segs.pop_front();
      if (got.seg_start !== want.seg_start)
        report_mismatch($sformatf("seg_start %0d, want %0d", got.seg_start, want.seg_start));
      if (got.seg_end !== want.seg_end)
        report_mismatch($sformatf("seg_end %0d, want %0d", got.seg_end, want.seg_end));
      if (got.last_in_run !== want.last_in_run)
        report_mismatch($sformatf("last_in_run %0b, want %0b", got.last_in_run,
                                  want.last_in_run));
    end
  endtask

  // segments go first: none can belong to an item taken on the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      invert_q  = 1'b0;
      min_gap_q = MIN_GAP_RESET;
      min_len_q = MIN_LENGTH_RESET;
      clear_stream();
      expected_segs.delete();
      n_fail = 0;
      n_segs = 0;
    end else begin
      if (out_valid && out_ready) check_segment(out_item);
      if (cfg_we) begin
        case (cfg_index)
          CFG_INVERT_MODE:       invert_q  = cfg_wdata[0];
          CFG_MIN_GAP_FRAMES:    min_gap_q = cfg_wdata[7:0];
          CFG_MIN_LENGTH_FRAMES: min_len_q = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) merge_frame(in_item.speech, in_item.final_frame);
    end
    fail_count    <= n_fail;
    seg_count     <= n_segs;
    pending_count <= expected_segs.size();
  end

endmodule

@@ dv/tb_speech_segment_merger.sv @@
// tb_speech_segment_merger: frame stimulus, register settings and verdict for
// speech_segment_merger; depends on ssm_pkg and ssm_checker
`timescale 1ns / 1ps

module tb_speech_segment_merger;
  import ssm_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RANDOM_CHUNK = 178;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned seg_count;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned frames_sent;
  int unsigned settings_used;

  // random stream shaper
  logic        gen_level;
  int unsigned gen_run_left;
  int unsigned gen_stream_left;

  speech_segment_merger dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ssm_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_item      (out_item),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .seg_count     (seg_count)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // receiver back-pressure
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    #(CLK_PERIOD * 400000);
    $display("Verification failed");
    $finish;
  end

  // present one frame item, idling first at random, and wait for it to be taken
  task automatic send_frame(input logic sp, input logic fin);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{speech: sp, final_frame: fin};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    frames_sent++;
  endtask

  // hold the input until every owed segment is out and the pipeline is empty
  task automatic drain();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic apply_settings(input logic inv, input logic [7:0] gap,
                                input logic [7:0] len);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_INVERT_MODE;
    cfg_wdata <= CFG_DATA_W'(inv);
    @(posedge clk);
    cfg_index <= CFG_MIN_GAP_FRAMES;
    cfg_wdata <= gap;
    @(posedge clk);
    cfg_index <= CFG_MIN_LENGTH_FRAMES;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic int unsigned pick_run();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 12);
    if (r < 90) return $urandom_range(13, 60);
    return $urandom_range(61, 320);
  endfunction

  // speech and silence runs of random length, a little flag noise, streams closed
  // by a final frame and now and then an early final frame
  task automatic next_frame(output logic sp, output logic fin);
    if (gen_stream_left == 0) begin
      gen_stream_left = ($urandom_range(0, 99) < 20) ? $urandom_range(1, 40)
                                                      : $urandom_range(41, 700);
      gen_level    = 1'($urandom_range(0, 1));
      gen_run_left = pick_run();
    end
    if (gen_run_left == 0) begin
      gen_level    = ~gen_level;
      gen_run_left = pick_run();
    end
    gen_run_left--;
    gen_stream_left--;
    sp  = gen_level;
    fin = (gen_stream_left == 0);
    if ($urandom_range(0, 99) < 4) sp = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 999) < 3) fin = 1'b1;
  endtask

  initial begin
    logic sp;
    logic fin;
    logic [7:0] gap;
    logic [7:0] len;

    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_item       <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_INVERT_MODE;
    cfg_wdata     <= '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    frames_sent   = 0;
    settings_used = 0;
    gen_level       = 1'b0;
    gen_run_left    = 0;
    gen_stream_left = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: a one-frame speech stream is too short to be emitted
    send_frame(1'b1, 1'b1);

    // two separate runs released at once by the final frame
    apply_settings(1'b0, 8'd2, 8'd1);
    send_frame(1'b1, 1'b0);
    send_frame(1'b1, 1'b0);
    send_frame(1'b0, 1'b0);
    send_frame(1'b0, 1'b0);
    send_frame(1'b0, 1'b0);
    send_frame(1'b1, 1'b0);
    send_frame(1'b0, 1'b0);
    send_frame(1'b0, 1'b0);
    send_frame(1'b0, 1'b0);
    send_frame(1'b1, 1'b1);

    // gaps with speech at frame 0: empty gaps never go out
    apply_settings(1'b1, 8'd0, 8'd0);
    send_frame(1'b1, 1'b0);
    send_frame(1'b0, 1'b0);
    send_frame(1'b1, 1'b0);
    send_frame(1'b1, 1'b1);
    // gap stream closed with no speech run open
    send_frame(1'b0, 1'b0);
    send_frame(1'b0, 1'b1);

    // mode switch in the middle of a stream, widest merge distance
    apply_settings(1'b0, 8'd255, 8'd255);
    send_frame(1'b1, 1'b0);
    send_frame(1'b1, 1'b0);
    send_frame(1'b0, 1'b0);
    apply_settings(1'b1, 8'd255, 8'd0);
    send_frame(1'b0, 1'b0);
    send_frame(1'b1, 1'b1);

    // random streams over three idle profiles, three settings each
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 34; recv_idle_pct = 81; end
        1: begin send_idle_pct = 81; recv_idle_pct = 34; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int chunk = 0; chunk < 3; chunk++) begin
        gap = 8'($urandom_range(0, 255));
        len = 8'($urandom_range(0, 255));
        case (phase * 3 + chunk)
          0: apply_settings(1'b0, 8'd0, 8'd0);
          1: apply_settings(1'b1, 8'd255, 8'd255);
          2: apply_settings(1'b0, 8'd3, 8'd8);
          3: apply_settings(1'b1, 8'd0, 8'd0);
          4: apply_settings(1'b0, 8'd255, 8'd0);
          5: apply_settings(1'b1, 8'd12, 8'd30);
          6: apply_settings(1'b0, 8'd0, 8'd255);
          7: apply_settings(1'b0, MIN_GAP_RESET, MIN_LENGTH_RESET);
          default: apply_settings(1'b1, gap, len);
        endcase
        for (int n = 0; n < RANDOM_CHUNK; n++) begin
          next_frame(sp, fin);
          send_frame(sp, fin);
        end
      end
    end

    drain();
    $display("covered %0d frame items and %0d segments over %0d register settings",
             frames_sent, seg_count, settings_used);
    $display("idle profiles: sender 34%%/receiver 81%%, the reverse, and none");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ speech_segment_merger.f @@
rtl/ssm_pkg.sv
rtl/speech_segment_merger.sv
dv/ssm_checker.sv
dv/tb_speech_segment_merger.sv
